// ===== rtl/core/complex_triangle_smoother_macros.svh =====
// complex_triangle_smoother_macros.svh: assertion macros for the smoother core
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef COMPLEX_TRIANGLE_SMOOTHER_MACROS_SVH
`define COMPLEX_TRIANGLE_SMOOTHER_MACROS_SVH

// checked only while out of reset
`define CTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define CTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/cts_pkg.sv =====
// cts_pkg: shared types and constants of the complex triangle smoother
// used by cts_ctrl, cts_dp and complex_triangle_smoother
package cts_pkg;

  // configuration register indexes
  localparam logic [2:0] CfgTraceLen  = 3'd0;
  localparam logic [2:0] CfgBoxLen    = 3'd1;
  localparam logic [2:0] CfgBoxMode   = 3'd2;
  localparam logic [2:0] CfgDerivMode = 3'd3;
  localparam logic [2:0] CfgWeight    = 3'd4;

  // datapath operations
  typedef enum logic [2:0] {
    OP_CLR    = 3'd0,
    OP_SPREAD = 3'd1,
    OP_INT    = 3'd2,
    OP_FOLD   = 3'd3,
    OP_OUT    = 3'd4
  } op_e;

  // spread tap weighting
  typedef enum logic [1:0] {
    TAP_NEG = 2'd0,
    TAP_POS = 2'd1,
    TAP_DBL = 2'd2
  } tap_e;

  typedef struct packed {
    logic issue;
    logic load;
    logic acc_clr;
    logic last;
    op_e  op;
    tap_e tap;
  } cmd_t;

  typedef struct packed {
    logic stg_vld;
    logic out_vld;
  } stat_t;

endpackage

// ===== rtl/core/cts_dp.sv =====
// cts_dp: work buffer memories, spread/integrate/fold arithmetic and output register
// depends on cts_pkg
module cts_dp #(
  parameter int MAX_LEN = 64,
  parameter int MAX_BOX = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cts_pkg::cmd_t          cmd_i,
  input  logic [$clog2(MAX_LEN+2*MAX_BOX)-1:0] addr_a_i,
  input  logic [$clog2(MAX_LEN+2*MAX_BOX)-1:0] addr_b_i,
  input  logic signed [15:0]     sample_re_i,
  input  logic signed [15:0]     sample_im_i,
  input  logic [16:0]            weight_i,
  input  logic                   out_ready_i,
  output cts_pkg::stat_t         stat_o,
  output logic signed [17:0]     smooth_re_o,
  output logic signed [17:0]     smooth_im_o,
  output logic                   last_o,
  output logic                   out_valid_o
);

  localparam int WorkDepth = MAX_LEN + 2 * MAX_BOX;
  localparam int AddrW     = $clog2(WorkDepth);

  logic signed [47:0] mem_re_q [WorkDepth];
  logic signed [47:0] mem_im_q [WorkDepth];
  logic signed [47:0] ra_re_q, ra_im_q, rb_re_q, rb_im_q;
  logic signed [47:0] acc_re_q, acc_im_q;
  logic signed [33:0] prod_re_q, prod_im_q;
  logic               stg_vld_q;
  cts_pkg::op_e       stg_op_q;
  cts_pkg::tap_e      stg_tap_q;
  logic               stg_last_q;
  logic [AddrW-1:0]   stg_addr_q;
  logic signed [47:0] wr_re, wr_im;
  logic               wr_en;
  logic               out_vld_q;
  logic signed [17:0] out_re_q, out_im_q;
  logic               out_last_q;

  // new value of one lane for the operation in the stage
  function automatic logic signed [47:0] lane_val(
    input cts_pkg::op_e       op,
    input cts_pkg::tap_e      tap,
    input logic signed [47:0] ra,
    input logic signed [47:0] rb,
    input logic signed [47:0] acc,
    input logic signed [33:0] prod
  );
    logic signed [47:0] ext;
    logic signed [47:0] res;
    ext = {{14{prod[33]}}, prod};
    res = '0;
    unique case (op)
      cts_pkg::OP_SPREAD: begin
        unique case (tap)
          cts_pkg::TAP_POS: res = ra + ext;
          cts_pkg::TAP_DBL: res = ra + (ext <<< 1);
          default:          res = ra - ext;
        endcase
      end
      cts_pkg::OP_INT:  res = acc + ra;
      cts_pkg::OP_FOLD: res = ra + rb;
      default:          res = '0;
    endcase
    return res;
  endfunction

  // round half up from Q.16 and saturate to 18 bits
  function automatic logic signed [17:0] round_sat(input logic signed [47:0] v);
    logic signed [48:0] t;
    logic signed [32:0] q;
    logic signed [17:0] r;
    t = {v[47], v} + 49'sd32768;
    q = t[48:16];
    if (q > 33'sd131071) begin
      r = 18'sd131071;
    end else if (q < -33'sd131072) begin
      r = -18'sd131072;
    end else begin
      r = q[17:0];
    end
    return r;
  endfunction

  assign wr_re = lane_val(stg_op_q, stg_tap_q, ra_re_q, rb_re_q, acc_re_q, prod_re_q);
  assign wr_im = lane_val(stg_op_q, stg_tap_q, ra_im_q, rb_im_q, acc_im_q, prod_im_q);
  assign wr_en = stg_vld_q && (stg_op_q != cts_pkg::OP_OUT);

  // work buffer: two registered read ports, one write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      ra_re_q <= mem_re_q[addr_a_i];
      ra_im_q <= mem_im_q[addr_a_i];
      rb_re_q <= mem_re_q[addr_b_i];
      rb_im_q <= mem_im_q[addr_b_i];
    end
    if (wr_en) begin
      mem_re_q[stg_addr_q] <= wr_re;
      mem_im_q[stg_addr_q] <= wr_im;
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else begin
      stg_vld_q <= cmd_i.issue;
    end
  end

  // stage payload, scaled sample and accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      stg_op_q   <= cmd_i.op;
      stg_tap_q  <= cmd_i.tap;
      stg_last_q <= cmd_i.last;
      stg_addr_q <= (cmd_i.op == cts_pkg::OP_FOLD) ? addr_b_i : addr_a_i;
    end
    if (cmd_i.load) begin
      prod_re_q <= $signed({1'b0, weight_i}) * sample_re_i;
      prod_im_q <= $signed({1'b0, weight_i}) * sample_im_i;
    end
    if (cmd_i.acc_clr) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (stg_vld_q && stg_op_q == cts_pkg::OP_INT) begin
      acc_re_q <= wr_re;
      acc_im_q <= wr_im;
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (stg_vld_q && stg_op_q == cts_pkg::OP_OUT) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_vld_q && stg_op_q == cts_pkg::OP_OUT) begin
      out_re_q   <= round_sat(ra_re_q);
      out_im_q   <= round_sat(ra_im_q);
      out_last_q <= stg_last_q;
    end
  end

  assign stat_o.stg_vld = stg_vld_q;
  assign stat_o.out_vld = out_vld_q;
  assign smooth_re_o    = out_re_q;
  assign smooth_im_o    = out_im_q;
  assign last_o         = out_last_q;
  assign out_valid_o    = out_vld_q;

endmodule

// ===== rtl/core/cts_ctrl.sv =====
// cts_ctrl: sequencer for load, spread, integration, fold, output and clear passes
// depends on cts_pkg and complex_triangle_smoother_macros.svh
`include "complex_triangle_smoother_macros.svh"

module cts_ctrl #(
  parameter int MAX_LEN = 64,
  parameter int MAX_BOX = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [$clog2(MAX_LEN+1)-1:0] nx_i,
  input  logic [$clog2(MAX_BOX+1)-1:0] nb_i,
  input  logic                   box_mode_i,
  input  logic                   back_i,
  input  cts_pkg::stat_t         stat_i,
  output cts_pkg::cmd_t          cmd_o,
  output logic [$clog2(MAX_LEN+2*MAX_BOX)-1:0] addr_a_o,
  output logic [$clog2(MAX_LEN+2*MAX_BOX)-1:0] addr_b_o
);

  localparam int WorkDepth = MAX_LEN + 2 * MAX_BOX;
  localparam int AddrW     = $clog2(WorkDepth);
  localparam int TgtW      = $clog2(MAX_LEN);

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_SPREAD = 8'b0000_0100,
    ST_INTF   = 8'b0000_1000,
    ST_INTB   = 8'b0001_0000,
    ST_FOLDR  = 8'b0010_0000,
    ST_FOLDL  = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [TgtW-1:0]  tgt_q, tgt_d;
  logic             up_q, up_d;
  logic [1:0]       tap_q, tap_d;
  logic             gap_q, gap_d;
  logic             done_q, done_d;
  logic [6:0]       lc_q, lc_d;
  logic [6:0]       lc_next;
  logic [AddrW-1:0] nx_a, nb_a, np_m1;
  logic [TgtW-1:0]  nx_m1;
  logic             last_tap;

  assign nx_a    = AddrW'(nx_i);
  assign nb_a    = AddrW'(nb_i);
  assign np_m1   = nx_a + (nb_a << 1) - AddrW'(1);
  assign nx_m1   = TgtW'(nx_i - 1'b1);
  assign lc_next = lc_q + 7'd1;

  // next state and commands
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    tgt_d    = tgt_q;
    up_d     = up_q;
    tap_d    = tap_q;
    done_d   = done_q;
    lc_d     = lc_q;
    cmd_o    = '0;
    addr_a_o = cnt_q;
    addr_b_o = nb_a + AddrW'(tgt_q);
    in_ready_o = 1'b0;
    last_tap = box_mode_i ? (tap_q == 2'd1) : (tap_q == 2'd2);

    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = cts_pkg::OP_CLR;
        if (cnt_q == AddrW'(WorkDepth - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          pos_d  = (lc_q >= 7'(MAX_LEN)) ? AddrW'(MAX_LEN - 1) : AddrW'(lc_q);
          done_d = (lc_next >= 7'(nx_i));
          lc_d   = (lc_next >= 7'(nx_i)) ? 7'd0 : lc_next;
          tap_d  = 2'd0;
          state_d = ST_SPREAD;
        end
      end

      ST_SPREAD: begin
        if (!gap_q) begin
          cmd_o.issue = 1'b1;
          cmd_o.op    = cts_pkg::OP_SPREAD;
          if (box_mode_i) begin
            if (tap_q == 2'd0) begin
              addr_a_o  = pos_q + AddrW'(1);
              cmd_o.tap = cts_pkg::TAP_POS;
            end else begin
              addr_a_o  = pos_q + (nb_a << 1);
              cmd_o.tap = cts_pkg::TAP_NEG;
            end
          end else begin
            unique case (tap_q)
              2'd0: begin
                addr_a_o  = pos_q;
                cmd_o.tap = cts_pkg::TAP_NEG;
              end
              2'd1: begin
                addr_a_o  = pos_q + nb_a;
                cmd_o.tap = cts_pkg::TAP_DBL;
              end
              default: begin
                addr_a_o  = pos_q + (nb_a << 1);
                cmd_o.tap = cts_pkg::TAP_NEG;
              end
            endcase
          end
          if (last_tap) begin
            cnt_d   = '0;
            state_d = done_q ? ST_INTF : ST_IDLE;
          end else begin
            tap_d = tap_q + 2'd1;
          end
        end
      end

      ST_INTF: begin
        cmd_o.acc_clr = gap_q;
        if (!gap_q) begin
          cmd_o.issue = 1'b1;
          cmd_o.op    = cts_pkg::OP_INT;
          if (cnt_q == np_m1) begin
            if (back_i) begin
              state_d = ST_INTB;
            end else begin
              cnt_d   = nx_a + nb_a;
              tgt_d   = nx_m1;
              up_d    = 1'b0;
              state_d = ST_FOLDR;
            end
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end

      ST_INTB: begin
        cmd_o.acc_clr = gap_q;
        if (!gap_q) begin
          cmd_o.issue = 1'b1;
          cmd_o.op    = cts_pkg::OP_INT;
          if (cnt_q == '0) begin
            cnt_d   = nx_a + nb_a;
            tgt_d   = nx_m1;
            up_d    = 1'b0;
            state_d = ST_FOLDR;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end

      ST_FOLDR, ST_FOLDL: begin
        // one padding entry folded into its mirrored trace slot at a time, once the previous fold write is done
        if (!gap_q && !stat_i.stg_vld) begin
          cmd_o.issue = 1'b1;
          cmd_o.op    = cts_pkg::OP_FOLD;
          if (up_q) begin
            if (tgt_q == nx_m1) up_d = 1'b0;
            else tgt_d = tgt_q + 1'b1;
          end else begin
            if (tgt_q == '0) up_d = 1'b1;
            else tgt_d = tgt_q - 1'b1;
          end
          if (state_q == ST_FOLDR) begin
            if (cnt_q == np_m1) begin
              cnt_d   = nb_a - AddrW'(1);
              tgt_d   = '0;
              up_d    = 1'b1;
              state_d = ST_FOLDL;
            end else begin
              cnt_d = cnt_q + 1'b1;
            end
          end else begin
            if (cnt_q == '0) begin
              state_d = ST_OUT;
            end else begin
              cnt_d = cnt_q - 1'b1;
            end
          end
        end
      end

      ST_OUT: begin
        addr_a_o = nb_a + cnt_q;
        if (!gap_q && !stat_i.stg_vld && !stat_i.out_vld) begin
          cmd_o.issue = 1'b1;
          cmd_o.op    = cts_pkg::OP_OUT;
          cmd_o.last  = (cnt_q == nx_a - AddrW'(1));
          if (cnt_q == nx_a - AddrW'(1)) begin
            cnt_d   = '0;
            state_d = ST_CLEAR;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end

      default: begin
        cnt_d   = '0;
        state_d = ST_CLEAR;
      end
    endcase

    gap_d = (state_d != state_q);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      pos_q   <= '0;
      tgt_q   <= '0;
      up_q    <= 1'b0;
      tap_q   <= '0;
      gap_q   <= 1'b0;
      done_q  <= 1'b0;
      lc_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      tgt_q   <= tgt_d;
      up_q    <= up_d;
      tap_q   <= tap_d;
      gap_q   <= gap_d;
      done_q  <= done_d;
      lc_q    <= lc_d;
    end
  end

  // fold reads must not overlap the previous fold write
  `CTS_ASSERT(a_fold_spacing, cmd_o.issue && (state_q == ST_FOLDR || state_q == ST_FOLDL) |-> !stat_i.stg_vld, "fold issued over pending write")
  // an output read needs a free output register
  `CTS_ASSERT(a_out_free, cmd_o.issue && cmd_o.op == cts_pkg::OP_OUT |-> !stat_i.out_vld, "output read with full register")
  // sample count stays inside one trace
  `CTS_ASSERT_ALWAYS(a_lc_range, lc_q < 7'(MAX_LEN), "load count out of range")

endmodule

// ===== rtl/core/complex_triangle_smoother.sv =====
// complex_triangle_smoother: top level with configuration registers and stream ports
// depends on cts_pkg, cts_ctrl and cts_dp
//
// Usage:
//   Write registers on the cfg channel (index 0 trace_length, 1 box_length,
//   2 box_mode, 3 derivative_mode, 4 weight) while the block is idle.
//   Samples enter on s_axis, one complex word per handshake. Each word is
//   taken and scaled by weight, then gets one read-modify-write of the work
//   buffer per spread tap (three taps, two in box mode), since the buffer
//   has a single write port; s_axis_tready stays low until its taps are done.
//   The word that completes a trace starts the smoothing passes: forward
//   integration over the trace_length + 2*box_length work entries, backward
//   integration in triangle mode without derivative_mode, the fold of
//   2*box_length padding entries, then trace_length output words, then a
//   clearing pass over all MAX_LEN + 2*MAX_BOX entries of the work buffer.
//   s_axis_tready is low through all of it.
//   Results leave on m_axis from an output register, m_axis_tlast marks the
//   final word of a trace. A stalled receiver holds the word and pauses the
//   output pass.
//   After reset the block runs the clearing pass before taking its first word.
module complex_triangle_smoother #(
  parameter int MAX_LEN = 64,
  parameter int MAX_BOX = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample_re [15:0], sample_im [31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // smooth_re [17:0], smooth_im [35:18], zero [39:36]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  localparam int AddrW = $clog2(MAX_LEN + 2 * MAX_BOX);
  localparam int LenW  = $clog2(MAX_LEN + 1);
  localparam int BoxW  = $clog2(MAX_BOX + 1);

  logic [6:0]  trace_len_q;
  logic [4:0]  box_len_q;
  logic        box_mode_q;
  logic        deriv_mode_q;
  logic [16:0] weight_q;
  logic [LenW-1:0] nx;
  logic [BoxW-1:0] nb;
  logic        back;
  cts_pkg::cmd_t  cmd;
  cts_pkg::stat_t stat;
  logic [AddrW-1:0] addr_a, addr_b;
  logic signed [17:0] smooth_re, smooth_im;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trace_len_q  <= 7'd64;
      box_len_q    <= 5'd1;
      box_mode_q   <= 1'b0;
      deriv_mode_q <= 1'b0;
      weight_q     <= 17'd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cts_pkg::CfgTraceLen:  trace_len_q  <= cfg_data_i[6:0];
        cts_pkg::CfgBoxLen:    box_len_q    <= cfg_data_i[4:0];
        cts_pkg::CfgBoxMode:   box_mode_q   <= cfg_data_i[0];
        cts_pkg::CfgDerivMode: deriv_mode_q <= cfg_data_i[0];
        cts_pkg::CfgWeight:    weight_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // clamp lengths into the supported range
  assign nx = (trace_len_q == 7'd0) ? LenW'(1) :
              (trace_len_q > 7'(MAX_LEN)) ? LenW'(MAX_LEN) : LenW'(trace_len_q);
  assign nb = (box_len_q == 5'd0) ? BoxW'(1) :
              (32'(box_len_q) > 32'(MAX_BOX)) ? BoxW'(MAX_BOX) : BoxW'(box_len_q);
  assign back = !box_mode_q && !deriv_mode_q;

  cts_ctrl #(
    .MAX_LEN (MAX_LEN),
    .MAX_BOX (MAX_BOX)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .nx_i       (nx),
    .nb_i       (nb),
    .box_mode_i (box_mode_q),
    .back_i     (back),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .addr_a_o   (addr_a),
    .addr_b_o   (addr_b)
  );

  cts_dp #(
    .MAX_LEN (MAX_LEN),
    .MAX_BOX (MAX_BOX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .addr_a_i    (addr_a),
    .addr_b_i    (addr_b),
    .sample_re_i (s_axis_tdata[15:0]),
    .sample_im_i (s_axis_tdata[31:16]),
    .weight_i    (weight_q),
    .out_ready_i (m_axis_tready),
    .stat_o      (stat),
    .smooth_re_o (smooth_re),
    .smooth_im_o (smooth_im),
    .last_o      (m_axis_tlast),
    .out_valid_o (m_axis_tvalid)
  );

  assign m_axis_tdata = {4'b0000, smooth_im, smooth_re};

endmodule

// ===== dv/complex_triangle_smoother_test.sv =====
// complex_triangle_smoother_test: self-checking bench for the complex triangle smoother
// holds its own bit-exact smoother model in a small scoreboard class; needs cts_pkg and the RTL

module complex_triangle_smoother_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TraceMax = 64;
  localparam int BoxMax   = 16;
  localparam int WorkSize = TraceMax + 2 * BoxMax;
  localparam int DrainGap = 400;

  typedef struct {
    logic signed [17:0] re;
    logic signed [17:0] im;
    logic               last;
  } smooth_word_t;

  // smoother model and store of pending smoothed words
  class smoother_scoreboard;
    logic [6:0]  len_reg;
    logic [4:0]  box_reg;
    logic        box_sel;
    logic        deriv_sel;
    logic [16:0] gain;
    longint      acc_re[WorkSize];
    longint      acc_im[WorkSize];
    int          loaded;
    int          errors;
    smooth_word_t pending[$];

    function void reset_state();
      len_reg = 7'd64;
      box_reg = 5'd1;
      box_sel = 1'b0;
      deriv_sel = 1'b0;
      gain = 17'd65536;
      loaded = 0;
      errors = 0;
      foreach (acc_re[k]) begin
        acc_re[k] = 0;
        acc_im[k] = 0;
      end
    endfunction

    function void set_reg(logic [2:0] idx, logic [16:0] val);
      case (idx)
        cts_pkg::CfgTraceLen:  len_reg = val[6:0];
        cts_pkg::CfgBoxLen:    box_reg = val[4:0];
        cts_pkg::CfgBoxMode:   box_sel = val[0];
        cts_pkg::CfgDerivMode: deriv_sel = val[0];
        cts_pkg::CfgWeight:    gain = val;
        default: ;
      endcase
    endfunction

    function longint wrap48(longint v);
      logic [63:0] u;
      u = v;
      return longint'({{16{u[47]}}, u[47:0]});
    endfunction

    // difference taps of one scaled sample
    function void spread_tap(ref longint wbuf[WorkSize], input int pos, input int nb,
                             input longint v);
      if (box_sel) begin
        wbuf[pos + 1] = wrap48(wbuf[pos + 1] + v);
        wbuf[pos + 2 * nb] = wrap48(wbuf[pos + 2 * nb] - v);
      end else begin
        wbuf[pos] = wrap48(wbuf[pos] - v);
        wbuf[pos + nb] = wrap48(wbuf[pos + nb] + 2 * v);
        wbuf[pos + 2 * nb] = wrap48(wbuf[pos + 2 * nb] - v);
      end
    endfunction

    function void run_sums(ref longint wbuf[WorkSize], input int np, input bit backward);
      longint acc;
      acc = 0;
      for (int k = 0; k < np; k++) begin
        acc = wrap48(acc + wbuf[k]);
        wbuf[k] = acc;
      end
      if (backward) begin
        acc = 0;
        for (int k = np - 1; k >= 0; k--) begin
          acc = wrap48(acc + wbuf[k]);
          wbuf[k] = acc;
        end
      end
    endfunction

    // mirror the padding back onto the trace at both ends
    function void fold(ref longint wbuf[WorkSize], input int nx, input int nb, input int np,
                       ref longint res[TraceMax]);
      int p;
      for (int k = 0; k < nx; k++) res[k] = wbuf[k + nb];
      for (p = nb + nx; p < np; p += nx) begin
        for (int k = 0; k < nx && k < np - p; k++)
          res[nx - 1 - k] = wrap48(res[nx - 1 - k] + wbuf[p + k]);
        p += nx;
        for (int k = 0; k < nx && k < np - p; k++)
          res[k] = wrap48(res[k] + wbuf[p + k]);
      end
      for (p = nb; p >= 0; p -= nx) begin
        for (int k = 0; k < nx && k < p; k++)
          res[k] = wrap48(res[k] + wbuf[p - 1 - k]);
        p -= nx;
        for (int k = 0; k < nx && k < p; k++)
          res[nx - 1 - k] = wrap48(res[nx - 1 - k] + wbuf[p - 1 - k]);
      end
    endfunction

    function logic signed [17:0] round_sat(longint v);
      longint q;
      q = (v + 32768) >>> 16;
      if (q > 131071) q = 131071;
      if (q < -131072) q = -131072;
      return q[17:0];
    endfunction

    // accepted sample: spread it, and smooth the trace when it is complete
    function void note_sample(logic signed [15:0] re, logic signed [15:0] im);
      int nx, nb, pos, np;
      longint res_re[TraceMax];
      longint res_im[TraceMax];
      smooth_word_t w;
      nx = (len_reg == 0) ? 1 : (len_reg > TraceMax) ? TraceMax : int'(len_reg);
      nb = (box_reg == 0) ? 1 : (box_reg > BoxMax) ? BoxMax : int'(box_reg);
      if (loaded == 0) begin
        foreach (acc_re[k]) begin
          acc_re[k] = 0;
          acc_im[k] = 0;
        end
      end
      pos = (loaded >= TraceMax) ? TraceMax - 1 : loaded;
      spread_tap(acc_re, pos, nb, longint'(re) * longint'(gain));
      spread_tap(acc_im, pos, nb, longint'(im) * longint'(gain));
      loaded = (loaded + 1) & 127;
      if (loaded < nx) return;
      np = nx + 2 * nb;
      run_sums(acc_re, np, !box_sel && !deriv_sel);
      run_sums(acc_im, np, !box_sel && !deriv_sel);
      fold(acc_re, nx, nb, np, res_re);
      fold(acc_im, nx, nb, np, res_im);
      for (int k = 0; k < nx; k++) begin
        w.re = round_sat(res_re[k]);
        w.im = round_sat(res_im[k]);
        w.last = (k == nx - 1);
        pending.push_back(w);
      end
      loaded = 0;
    endfunction

    function void check_word(logic [39:0] data, logic last);
      smooth_word_t w;
      if (pending.size() == 0) begin
        $error("smoothed word with nothing pending: %h", data);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (data[17:0] !== w.re) begin
        $error("smooth_re expected %0d got %0d", w.re, $signed(data[17:0]));
        errors++;
      end
      if (data[35:18] !== w.im) begin
        $error("smooth_im expected %0d got %0d", w.im, $signed(data[35:18]));
        errors++;
      end
      if (last !== w.last) begin
        $error("last_out expected %0b got %0b", w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [16:0] cfg_data_i;

  smoother_scoreboard sb;
  int sent;
  int stall_left;
  int calm_left;

  complex_triangle_smoother dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // fixed run limit
  initial begin
    #100ms;
    $display("FAIL complex_triangle_smoother");
    $finish;
  end

  // receiver: stall bursts, with calm stretches
  always @(negedge clk_i) begin
    if (calm_left > 0) begin
      calm_left <= calm_left - 1;
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 40) == 0) begin
      calm_left <= $urandom_range(50, 300);
      m_axis_tready <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // check every accepted output word
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tlast);
  end

  // one sample word; valid stays high for a following burst word
  task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {im, re};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(re, im);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic sender_gap(int cycles);
    s_axis_tvalid = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [16:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // registers only change once the block has gone quiet
  task automatic configure(logic [6:0] len, logic [4:0] nb, logic box, logic deriv,
                           logic [16:0] gain);
    wait_drained();
    repeat (DrainGap) @(negedge clk_i);
    write_reg(cts_pkg::CfgTraceLen, len);
    write_reg(cts_pkg::CfgBoxLen, nb);
    write_reg(cts_pkg::CfgBoxMode, box);
    write_reg(cts_pkg::CfgDerivMode, deriv);
    write_reg(cts_pkg::CfgWeight, gain);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int len, nb, traces, burst;
    logic [16:0] gain;
    sb = new();
    sb.reset_state();
    sent = 0;
    stall_left = 0;
    calm_left = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = cts_pkg::CfgTraceLen;
    cfg_data_i = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extreme samples in every mode
    configure(7'd4, 5'd1, 1'b0, 1'b0, 17'd65536);
    send_sample(16'sh7fff, -16'sd32768);
    send_sample(-16'sd32768, 16'sh7fff);
    send_sample(16'sd0, -16'sd1);
    send_sample(16'sd1, 16'sd0);
    configure(7'd3, 5'd2, 1'b1, 1'b0, 17'd21845);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(-16'sd32768, -16'sd32768);
    send_sample(16'sd100, -16'sd100);
    configure(7'd3, 5'd2, 1'b0, 1'b1, 17'd16384);
    send_sample(16'sh7fff, -16'sd32768);
    send_sample(16'sd5, 16'sd7);
    send_sample(-16'sd9, 16'sd3);
    // zero length and zero box act as one; gain near two saturates
    configure(7'd0, 5'd0, 1'b0, 1'b0, 17'h1ffff);
    send_sample(16'sh7fff, -16'sd32768);
    send_sample(-16'sd32768, 16'sh7fff);
    // oversized box with a short trace folds many times
    configure(7'd2, 5'd31, 1'b1, 1'b1, 17'd0);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sd1, -16'sd1);
    configure(7'd2, 5'd16, 1'b0, 1'b0, 17'd256);
    send_sample(16'sh7fff, -16'sd32768);
    send_sample(-16'sd32768, 16'sh7fff);

    // random phases, mostly short traces
    while (sent < 360) begin
      case ($urandom_range(0, 9))
        0: len = 64;
        1: len = $urandom_range(65, 127);
        2: len = 0;
        default: len = $urandom_range(1, 8);
      endcase
      nb = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
      case ($urandom_range(0, 5))
        0: gain = 17'($urandom);
        1: gain = 17'd65536;
        default: gain = 17'($urandom_range(0, 65536));
      endcase
      configure(7'(len), 5'(nb), 1'($urandom), 1'($urandom), gain);
      if (len == 0) len = 1;
      if (len > TraceMax) len = TraceMax;
      traces = (len > 16) ? 1 : $urandom_range(1, 4);
      repeat (traces) begin
        for (int k = 0; k < len; k += burst) begin
          burst = $urandom_range(1, 6);
          for (int j = 0; j < burst && k + j < len; j++)
            send_sample(rand_sample(), rand_sample());
          if ($urandom_range(0, 2) == 0) sender_gap($urandom_range(1, 10));
        end
        if ($urandom_range(0, 7) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (DrainGap) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS complex_triangle_smoother");
    end else begin
      $display("FAIL complex_triangle_smoother");
    end
    $finish;
  end

endmodule
